// ===== rtl/core/haar_2d_analysis_top_assert.svh =====
// Assertion macros for the 2-D Haar analysis block.
// Used by haar_2d_analysis_top; expects clk and rst_n in scope.
`ifndef HAAR_2D_ANALYSIS_TOP_ASSERT_SVH
`define HAAR_2D_ANALYSIS_TOP_ASSERT_SVH

// same-cycle implication
`define HAAR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HAAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/haar_pkg.sv =====
// Types and fixed constants of the 2-D Haar analysis block.
// No dependencies.
package haar_pkg;

  localparam int CFG_DATA_W   = 13;
  localparam int IMG_W_BITS   = 11;
  localparam int IMG_H_BITS   = 13;
  localparam int ROW_W        = 12;
  localparam int MAX_HEIGHT   = 4096;
  localparam int RST_WIDTH    = 1024;
  localparam int RST_HEIGHT   = 1024;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

// ===== rtl/core/haar_2d_analysis_top.sv =====
// Result registered on acceptance of a 2x2 block's bottom-right pixel. One pixel per cycle,
// unless a result waits on out_ready; set by the single-port pair row store and output register.
// Reset: synchronous, active low; size registers go to 1024x1024, width capped at MAX_WIDTH;
// counters and held pixel to zero. The row store is not initialized and needs no clearing pass.
// Depends on haar_pkg and haar_2d_analysis_top_assert.svh.
`include "haar_2d_analysis_top_assert.svh"

module haar_2d_analysis_top
  import haar_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PIXEL_BITS-1:0]   in_pixel,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PIXEL_BITS+1:0]   out_band_ll,
  output logic [PIXEL_BITS+1:0]   out_band_lh,
  output logic [PIXEL_BITS+1:0]   out_band_hl,
  output logic [PIXEL_BITS+1:0]   out_band_hh,
  output logic                    out_frame_last
);

  localparam int BAND_W    = PIXEL_BITS + 2;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ADDR_W    = (COL_W > 1) ? COL_W - 1 : 1;
  localparam int MEM_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int RST_W_EFF = (MAX_WIDTH < RST_WIDTH) ? MAX_WIDTH : RST_WIDTH;
  localparam int RST_LASTC = (RST_W_EFF / 2) * 2 - 1;
  localparam int RST_LASTR = (RST_HEIGHT / 2) * 2 - 1;

  logic [COL_W-1:0]        col_r, col_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic [COL_W-1:0]        last_col_r, last_col_nxt;
  logic [COL_W-1:0]        lastc_r, lastc_nxt;
  logic [ROW_W-1:0]        last_row_r, last_row_nxt;
  logic [ROW_W-1:0]        lastr_r, lastr_nxt;
  logic [PIXEL_BITS-1:0]   hold_r, hold_nxt;

  logic [2*PIXEL_BITS-1:0] mem [MEM_DEPTH];
  logic [2*PIXEL_BITS-1:0] rd_q_r;
  logic [ADDR_W-1:0]       mem_addr;
  logic                    mem_we;
  logic                    mem_re;

  logic                    out_valid_r;
  logic [BAND_W-1:0]       ll_r, lh_r, hl_r, hh_r;
  logic                    last_r;

  logic                    in_fire;
  logic                    produce;
  logic [IMG_W_BITS-1:0]   w_raw, w_eff;
  logic [IMG_H_BITS-1:0]   h_raw, h_eff;
  logic [BAND_W-1:0]       x00, x01, x10, x11;
  logic [BAND_W-1:0]       s0, d0, s1, d1;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign produce   = in_fire && row_r[0] && col_r[0];

  assign mem_addr  = ADDR_W'(col_r >> 1);
  assign mem_we    = in_fire && !row_r[0] && col_r[0];
  assign mem_re    = in_fire && row_r[0] && !col_r[0];

  // clamp configuration values
  always_comb begin
    w_raw = cfg_wdata[IMG_W_BITS-1:0];
    h_raw = cfg_wdata[IMG_H_BITS-1:0];
    w_eff = w_raw;
    if (int'(w_raw) < 2) begin
      w_eff = IMG_W_BITS'(2);
    end else if (int'(w_raw) > MAX_WIDTH) begin
      w_eff = IMG_W_BITS'(MAX_WIDTH);
    end
    h_eff = h_raw;
    if (int'(h_raw) < 2) begin
      h_eff = IMG_H_BITS'(2);
    end else if (int'(h_raw) > MAX_HEIGHT) begin
      h_eff = IMG_H_BITS'(MAX_HEIGHT);
    end
  end

  always_comb begin
    last_col_nxt = last_col_r;
    lastc_nxt    = lastc_r;
    last_row_nxt = last_row_r;
    lastr_nxt    = lastr_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    hold_nxt     = hold_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH: begin
          last_col_nxt = COL_W'(w_eff - IMG_W_BITS'(1));
          lastc_nxt    = COL_W'((w_eff & ~IMG_W_BITS'(1)) - IMG_W_BITS'(1));
        end
        REG_IMAGE_HEIGHT: begin
          last_row_nxt = ROW_W'(h_eff - IMG_H_BITS'(1));
          lastr_nxt    = ROW_W'((h_eff & ~IMG_H_BITS'(1)) - IMG_H_BITS'(1));
        end
        default: begin
          last_col_nxt = last_col_r;
        end
      endcase
      col_nxt  = '0;
      row_nxt  = '0;
      hold_nxt = '0;
    end else if (in_fire) begin
      if (!col_r[0]) begin
        hold_nxt = in_pixel;
      end
      if (col_r == last_col_r) begin
        col_nxt = '0;
        row_nxt = (row_r == last_row_r) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= COL_W'(RST_W_EFF - 1);
      lastc_r    <= COL_W'(RST_LASTC);
      last_row_r <= ROW_W'(RST_HEIGHT - 1);
      lastr_r    <= ROW_W'(RST_LASTR);
      col_r      <= '0;
      row_r      <= '0;
      hold_r     <= '0;
    end else begin
      last_col_r <= last_col_nxt;
      lastc_r    <= lastc_nxt;
      last_row_r <= last_row_nxt;
      lastr_r    <= lastr_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      hold_r     <= hold_nxt;
    end
  end

  // pair row store: low half is the left pixel, high half the right pixel
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {in_pixel, hold_r};
    end
    if (mem_re) begin
      rd_q_r <= mem[mem_addr];
    end
  end

  assign x00 = {{2{rd_q_r[PIXEL_BITS-1]}}, rd_q_r[PIXEL_BITS-1:0]};
  assign x10 = {{2{rd_q_r[2*PIXEL_BITS-1]}}, rd_q_r[2*PIXEL_BITS-1:PIXEL_BITS]};
  assign x01 = {{2{hold_r[PIXEL_BITS-1]}}, hold_r};
  assign x11 = {{2{in_pixel[PIXEL_BITS-1]}}, in_pixel};

  assign s0 = x00 + x01;
  assign d0 = x00 - x01;
  assign s1 = x10 + x11;
  assign d1 = x10 - x11;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (produce) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      ll_r   <= s0 + s1;
      lh_r   <= s0 - s1;
      hl_r   <= d0 + d1;
      hh_r   <= d0 - d1;
      last_r <= (col_r == lastc_r) && (row_r == lastr_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_band_ll    = ll_r;
  assign out_band_lh    = lh_r;
  assign out_band_hl    = hl_r;
  assign out_band_hh    = hh_r;
  assign out_frame_last = last_r;

  `HAAR_ASSERT_NEXT(a_result_follows, produce, out_valid_r, "block result not presented")
  `HAAR_ASSERT_NOW(a_col_bound, 1'b1, col_r <= last_col_r, "column counter past row end")
  `HAAR_ASSERT_NOW(a_row_bound, 1'b1, row_r <= last_row_r, "row counter past frame end")
  `HAAR_ASSERT_NOW(a_mem_port, 1'b1, !(mem_we && mem_re), "row store read and write collide")

endmodule
